/* rtl/gfnt_pkg.sv */
// shared types and constants for the gf(2^16) nibble table butterfly
`timescale 1ns / 1ps
`default_nettype none

package gfnt_pkg;

	localparam int ELEM_W    = 16;
	localparam int NIB_W     = 4;
	localparam int SLOTS     = ELEM_W / NIB_W;
	localparam int ENTRIES   = 1 << NIB_W;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int OP_W      = 3;
	localparam int IN_DATA_W = 56;
	localparam int OUT_DATA_W = 32;

	localparam logic [NIB_W-1:0] NIB_MASK = 4'h0f;

	typedef logic [ELEM_W-1:0] elem_t;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 3'd0,
		OP_MULADD = 3'd1,
		OP_FWD    = 3'd2,
		OP_INV    = 3'd3,
		OP_MUL    = 3'd4
	} op_t;

	// stage 1 state handed to the result logic
	typedef struct packed {
		op_t   op;
		elem_t a;
		elem_t b;
	} stage_t;

endpackage

`default_nettype wire

/* rtl/gfnt_nibble_ram.sv */
// one 16-entry nibble table memory with per-entry valid bits and registered read
`timescale 1ns / 1ps
`default_nettype none

module gfnt_nibble_ram
	import gfnt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [NIB_W-1:0] waddr,
	input  wire elem_t            wdata,
	input  wire logic             re,
	input  wire logic [NIB_W-1:0] raddr,
	output elem_t                 rdata
);

	elem_t              mem_q [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	elem_t              rd_q;
	logic               rd_vld_q;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	// entry valid bits, cleared at reset so unwritten entries read zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

/* rtl/gfnt_result.sv */
// product reduction and butterfly result for one element pair
`timescale 1ns / 1ps
`default_nettype none

module gfnt_result
	import gfnt_pkg::*;
(
	input  stage_t st,
	input  elem_t  words [SLOTS],
	output elem_t  a_out,
	output elem_t  b_out
);

	elem_t prod;
	elem_t a_acc;

	// xor of the four table words
	always_comb begin
		prod = '0;
		for (int i = 0; i < SLOTS; i++) begin
			prod = prod ^ words[i];
		end
	end

	assign a_acc = st.a ^ prod;

	// per-operation update of the pair
	always_comb begin
		a_out = st.a;
		b_out = st.b;
		unique case (st.op)
			OP_MULADD: begin
				a_out = a_acc;
			end
			OP_FWD: begin
				a_out = a_acc;
				b_out = st.b ^ a_acc;
			end
			OP_INV: begin
				a_out = a_acc;
				b_out = st.b ^ st.a;
			end
			OP_MUL: begin
				a_out = prod;
			end
			default: begin
				a_out = st.a;
				b_out = st.b;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/gf16_nibble_table_butterfly.sv */
// GF(2^16) nibble table multiply, muladd and butterfly streaming block
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per cycle while back pressure does not hold the pipeline;
// a pair item passes stage 1, then the output register. The table store is
// four 16-entry memories, one per nibble of the operand, each read once per
// item so that all four table words arrive together in stage 1. Load items
// (opcode 0) write one entry and give no result; opcodes 5 to 7 are dropped.
// Per-entry valid bits clear at reset, so the tables read as zero right away
// and no clearing pass is needed. Back pressure on the output holds the
// pipeline in place; the input keeps accepting while the stage ahead can move.

module gf16_nibble_table_butterfly
	import gfnt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// a_value[15:0], b_value[31:16], nibble_slot[33:32], entry_index[37:34],
	// table_word[53:38], zero pad[55:54]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// opcode[2:0]
	input  wire logic [OP_W-1:0]       s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// a_out[15:0], b_out[31:16]
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	op_t               in_op;
	elem_t             in_a;
	elem_t             in_b;
	logic [SLOT_W-1:0] in_slot;
	logic [NIB_W-1:0]  in_entry;
	elem_t             in_word;
	logic              in_fire;
	logic              is_load;
	logic              is_calc;
	elem_t             operand;

	logic              valid_s1;
	stage_t            st_s1;
	logic              out_free;
	logic              adv_s1;

	logic              m_valid_q;
	elem_t             a_out_q;
	elem_t             b_out_q;
	elem_t             a_res;
	elem_t             b_res;
	elem_t             words [SLOTS];

	// input field unpack
	assign in_op    = op_t'(s_tuser);
	assign in_a     = s_tdata[15:0];
	assign in_b     = s_tdata[31:16];
	assign in_slot  = s_tdata[33:32];
	assign in_entry = s_tdata[37:34];
	assign in_word  = s_tdata[53:38];

	// opcode decode and multiplied operand
	always_comb begin
		is_load = 1'b0;
		is_calc = 1'b0;
		operand = in_b;
		unique case (in_op)
			OP_LOAD: begin
				is_load = 1'b1;
			end
			OP_MULADD, OP_FWD: begin
				is_calc = 1'b1;
				operand = in_b;
			end
			OP_INV: begin
				is_calc = 1'b1;
				operand = in_b ^ in_a;
			end
			OP_MUL: begin
				is_calc = 1'b1;
				operand = in_a;
			end
			default: begin
				is_load = 1'b0;
				is_calc = 1'b0;
			end
		endcase
	end

	// handshake: stage 1 moves when the output register is free or draining
	assign out_free = !m_valid_q || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_fire  = s_tvalid && s_tready;

	// four nibble table memories
	for (genvar g = 0; g < SLOTS; g++) begin : g_slot
		gfnt_nibble_ram u_ram (
			.clk    (clk),
			.arst_n (arst_n),
			.we     (in_fire && is_load && (in_slot == SLOT_W'(g))),
			.waddr  (in_entry),
			.wdata  (in_word),
			.re     (in_fire && is_calc),
			.raddr  (operand[g*NIB_W +: NIB_W] & NIB_MASK),
			.rdata  (words[g])
		);
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= in_fire && is_calc;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire && is_calc) begin
			st_s1.op <= in_op;
			st_s1.a  <= in_a;
			st_s1.b  <= in_b;
		end
	end

	gfnt_result u_result (
		.st    (st_s1),
		.words (words),
		.a_out (a_res),
		.b_out (b_res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			a_out_q <= a_res;
			b_out_q <= b_res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {b_out_q, a_out_q};

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// testbench for the gf(2^16) nibble table multiply, muladd and butterfly block
`timescale 1ns / 1ps

module tb_top;
	import gfnt_pkg::*;

	localparam int                CLK_HALF     = 2;
	localparam int                HOLD_CYCLES  = 400;
	localparam int                SETTLE       = 20;
	localparam int                MAX_REPORTS  = 10;
	localparam int                IDLE_PCT     = 36;
	localparam logic [OP_W-1:0]   OP_SPARE_LO  = 3'd5;
	localparam logic [OP_W-1:0]   OP_SPARE_HI  = 3'd7;
	localparam elem_t             ELEM_ONES    = 16'hffff;

	typedef struct {
		elem_t a;
		elem_t b;
	} pair_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [OP_W-1:0]       s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// predictor state: the four nibble tables, slot in the upper index bits
	elem_t gf_table [SLOTS*ENTRIES] = '{default: '0};
	pair_t expected_pairs [$];

	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit hold_req  = 1'b0;
	int hold_count = 0;
	int n_mismatch = 0;
	int n_results  = 0;
	int n_useful   = 0;
	int op_seen [1 << OP_W];

	gf16_nibble_table_butterfly uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #(CLK_HALF) clk = ~clk;

	// product of v by the loaded constant: xor of one entry per nibble
	function automatic elem_t table_mul(elem_t v);
		elem_t acc;
		acc = '0;
		for (int s = 0; s < SLOTS; s++)
			acc ^= gf_table[s*ENTRIES + ((v >> (NIB_W*s)) & NIB_MASK)];
		return acc;
	endfunction

	// update the tables or queue the expected pair for one accepted item
	function automatic void track_item(logic [OP_W-1:0] op, elem_t a, elem_t b,
			logic [SLOT_W-1:0] slot, logic [NIB_W-1:0] idx, elem_t word);
		pair_t r;
		r.a = a;
		r.b = b;
		op_seen[op]++;
		case (op)
			OP_LOAD: begin
				gf_table[{slot, idx}] = word;
				n_useful++;
				return;
			end
			OP_MULADD: r.a = a ^ table_mul(b);
			OP_FWD: begin
				r.a = a ^ table_mul(b);
				r.b = b ^ r.a;
			end
			OP_INV: begin
				r.b = b ^ a;
				r.a = a ^ table_mul(r.b);
			end
			OP_MUL: r.a = table_mul(a);
			default: return;
		endcase
		n_useful++;
		expected_pairs.push_back(r);
	endfunction

	task automatic note_mismatch(string what, elem_t want, elem_t got);
		n_mismatch++;
		if (n_mismatch <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %04h, got %04h", $realtime, what, want, got);
	endtask

	// offer one item, with random idle cycles first, and wait for it to be taken
	task automatic send_item(logic [OP_W-1:0] op, elem_t a, elem_t b,
			logic [SLOT_W-1:0] slot, logic [NIB_W-1:0] idx, elem_t word);
		while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, word, idx, slot, b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_item(op, a, b, slot, idx, word);
	endtask

	function automatic elem_t rand_elem();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return ELEM_ONES;
		return elem_t'($urandom);
	endfunction

	// one random item: mostly element pairs, some loads, a few spare opcodes
	task automatic send_random();
		int pick;
		elem_t a;
		elem_t b;
		pick = $urandom_range(99);
		a = rand_elem();
		b = rand_elem();
		if (pick < 12)
			send_item(OP_LOAD, a, b, SLOT_W'($urandom_range(SLOTS-1)),
				NIB_W'($urandom_range(ENTRIES-1)), rand_elem());
		else if (pick < 16)
			send_item(OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), a, b,
				SLOT_W'($urandom), NIB_W'($urandom), elem_t'($urandom));
		else
			send_item(OP_W'($urandom_range(OP_MUL, OP_MULADD)), a, b,
				SLOT_W'($urandom), NIB_W'($urandom), elem_t'($urandom));
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// output side: random stalls, steady stretches, and a long counted hold
	always @(posedge clk) begin
		if (hold_req) begin
			hold_count = HOLD_CYCLES;
			hold_req   = 1'b0;
		end
		if (hold_count > 0) begin
			hold_count--;
			m_tready <= 1'b0;
		end else if (rx_steady) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// compare each result, field by field, with the oldest expected pair
	always @(posedge clk) begin : result_check
		pair_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (expected_pairs.size() == 0) begin
				note_mismatch("unexpected result a_out", '0, m_tdata[15:0]);
			end else begin
				want = expected_pairs.pop_front();
				if (m_tdata[15:0] !== want.a)
					note_mismatch("a_out", want.a, m_tdata[15:0]);
				if (m_tdata[31:16] !== want.b)
					note_mismatch("b_out", want.b, m_tdata[31:16]);
			end
		end
	end

	// every operation on the cleared tables gives a zero product
	task automatic test_empty_tables();
		send_item(OP_MULADD, ELEM_ONES, ELEM_ONES, '0, '0, '0);
		send_item(OP_FWD, 16'h1234, ELEM_ONES, '0, '0, '0);
		send_item(OP_INV, ELEM_ONES, '0, '0, '0, '0);
		send_item(OP_MUL, ELEM_ONES, ELEM_ONES, '0, '0, '0);
	endtask

	// extreme entries, all operations, spare opcodes, load then immediate use
	task automatic test_directed_loads();
		send_item(OP_LOAD, '0, '0, 2'd0, 4'd0, ELEM_ONES);
		send_item(OP_LOAD, '0, '0, 2'd0, 4'd15, 16'h8001);
		send_item(OP_LOAD, '0, '0, 2'd3, 4'd15, ELEM_ONES);
		send_item(OP_LOAD, '0, '0, 2'd3, 4'd0, 16'h0001);
		send_item(OP_LOAD, '0, '0, 2'd1, 4'd5, 16'ha5a5);
		send_item(OP_LOAD, '0, '0, 2'd2, 4'd10, 16'h5a5a);
		send_item(OP_MUL, '0, ELEM_ONES, '0, '0, '0);
		send_item(OP_MUL, ELEM_ONES, '0, '0, '0, '0);
		send_item(OP_MULADD, '0, ELEM_ONES, '0, '0, '0);
		send_item(OP_FWD, ELEM_ONES, 16'hf00f, '0, '0, '0);
		send_item(OP_INV, 16'h0f0f, ELEM_ONES, '0, '0, '0);
		send_item(OP_MUL, 16'h0a50, 16'h1111, '0, '0, '0);
		// spare opcodes must neither load nor answer
		send_item(OP_SPARE_LO, ELEM_ONES, ELEM_ONES, 2'd0, 4'd0, 16'h1357);
		send_item(OP_SPARE_LO + 3'd1, 16'h00ff, 16'hff00, 2'd3, 4'd15, 16'h2468);
		send_item(OP_SPARE_HI, ELEM_ONES, '0, 2'd1, 4'd5, ELEM_ONES);
		// overwrite an entry and read it on the very next item
		send_item(OP_LOAD, '0, '0, 2'd0, 4'd0, '0);
		send_item(OP_MUL, '0, '0, '0, '0, '0);
		send_item(OP_LOAD, '0, '0, 2'd3, 4'd15, 16'h7e81);
		send_item(OP_INV, 16'hf000, 16'h0fff, '0, '0, '0);
	endtask

	// fill every entry with random words, then a long random mix
	task automatic test_random_mix(int count);
		int target;
		for (int e = 0; e < SLOTS*ENTRIES; e++)
			send_item(OP_LOAD, rand_elem(), rand_elem(), SLOT_W'(e / ENTRIES),
				NIB_W'(e % ENTRIES), elem_t'($urandom));
		target = n_useful + count;
		while (n_useful < target)
			send_random();
	endtask

	// output held off for a long stretch while items keep coming
	task automatic test_output_hold(int count);
		int target;
		tx_steady = 1'b1;
		hold_req  = 1'b1;
		target = n_useful + count;
		while (n_useful < target)
			send_random();
		tx_steady = 1'b0;
	endtask

	// no idling on either side: one item per cycle
	task automatic test_full_rate(int count);
		int target;
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		target = n_useful + count;
		while (n_useful < target)
			send_random();
		wait_drain();
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_tables();
		test_directed_loads();
		test_random_mix(900);
		test_output_hold(150);
		test_full_rate(250);
		wait_drain();
		$display("covered %0d loads, %0d muladd, %0d forward, %0d inverse, %0d multiply",
			op_seen[OP_LOAD], op_seen[OP_MULADD], op_seen[OP_FWD], op_seen[OP_INV],
			op_seen[OP_MUL]);
		$display("%0d spare opcodes dropped, %0d results checked, %0d-cycle output hold",
			op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_LO + 3'd1] + op_seen[OP_SPARE_HI],
			n_results, HOLD_CYCLES);
		if (n_mismatch == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog for a stuck handshake
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
